>>> rtl/bce_pkg.sv
// Package for the Bezier curve evaluator: default sizes, register indexes,
// curve order codes and the control word that travels down the pipeline.
// No dependencies.
`timescale 1ns / 1ps

package bce_pkg;

	localparam int COORD_WIDTH_DEF     = 16;
	localparam int PARAM_FRAC_BITS_DEF = 16;

	// Pipeline depth from input register to output register.
	localparam int PIPE_STAGES = 7;

	// Wide products are split into limbs of this many bits.
	localparam int LIMB_W = 24;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT_ZERO  = 3'd0,
		REG_POINT_ONE   = 3'd1,
		REG_POINT_TWO   = 3'd2,
		REG_POINT_THREE = 3'd3,
		REG_CURVE_ORDER = 3'd4
	} cfg_reg_t;

	localparam logic [1:0] ORDER_QUAD  = 2'd2;
	localparam logic [1:0] ORDER_CUBIC = 2'd3;
	localparam logic [1:0] ORDER_RESET = ORDER_CUBIC;

	typedef struct packed {
		logic zero;
		logic cubic;
	} ctl_t;

endpackage

>>> rtl/bezier_curve_evaluate.sv
// Top level of the quadratic and cubic Bezier curve evaluator: configuration
// registers, valid and stall control, and the seven-stage datapath.
// Depends on bce_pkg, bce_coef, bce_lerp, bce_wide_mul and bce_round_sat.
//
// Usage:
//   The slave stream carries one parameter u per word (unsigned Q1.16 at the
//   default size, values above 1.0 are taken as 1.0). The master stream
//   returns the curve point at u, x in the low half and y in the high half,
//   each signed Q12.4, rounded to nearest and saturated.
//   The user must write control points and curve order on the cfg port only
//   while no word is in flight; the block does not enforce this. Order 3 is
//   cubic, 2 quadratic, any other gives (0,0). Throughput is one word per
//   cycle while the output is not stalled. There are seven register stages:
//   coefficient selection, the first blend level, two stages for each of the
//   two wide multiply levels, and rounding with saturation.
//   Each stage advances on its own, so empty stages fill up while m_tready
//   is low; s_tready drops only when all seven stages hold a word.
//   Reset clears all valid bits and sets the points to the origin and the
//   order to cubic.
`timescale 1ns / 1ps

module bezier_curve_evaluate #(
	parameter int COORD_WIDTH     = bce_pkg::COORD_WIDTH_DEF,
	parameter int PARAM_FRAC_BITS = bce_pkg::PARAM_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// param_u
	input  logic [((PARAM_FRAC_BITS+8)/8)*8-1:0]   s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// point_x, point_y
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
	input  logic                                   cfg_wen,
	input  logic [bce_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [2*COORD_WIDTH-1:0]               cfg_data
);
	import bce_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int F     = PARAM_FRAC_BITS;
	localparam int OUT_W = ((2 * CW + 7) / 8) * 8;
	localparam int W1    = CW + F + 2;
	localparam int W2    = W1 + F;
	localparam int W3    = W2 + F;
	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

	logic [2*CW-1:0] points_q [4];
	logic [1:0]      order_q;

	logic [PIPE_STAGES:1] vld_q;
	logic [PIPE_STAGES:1] adv;
	logic [PIPE_STAGES:1] vld_in;

	logic [F:0]           u_s1, v_s1, u_s2, v_s2, u_s3, v_s3;
	logic [F:0]           fl_s4, fr_s4;
	logic signed [CW+1:0] cx_s1 [4];
	logic signed [CW+1:0] cy_s1 [4];
	ctl_t                 ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic signed [W1-1:0] xl_s2, xr_s2, yl_s2, yr_s2;
	logic signed [W2-1:0] xl_s4, xr_s4, yl_s4, yr_s4;
	logic signed [W3-1:0] xl_s6, xr_s6, yl_s6, yr_s6;
	logic signed [CW-1:0] x_s7, y_s7;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				points_q[i] <= '0;
			end
			order_q <= ORDER_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_POINT_ZERO:  points_q[0] <= cfg_data;
				REG_POINT_ONE:   points_q[1] <= cfg_data;
				REG_POINT_TWO:   points_q[2] <= cfg_data;
				REG_POINT_THREE: points_q[3] <= cfg_data;
				REG_CURVE_ORDER: order_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// A stage takes a new word when it is empty or its word moves on.
	always_comb begin
		adv[PIPE_STAGES] = !vld_q[PIPE_STAGES] || m_tready;
		for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
		vld_in = {vld_q[PIPE_STAGES-1:1], s_tvalid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= PIPE_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign s_tready = adv[1];
	assign m_tvalid = vld_q[PIPE_STAGES];
	assign m_tdata  = OUT_W'({y_s7, x_s7});

	bce_coef #(.CW(CW), .F(F)) u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv[1]),
		.param_u (s_tdata[F:0]),
		.points  (points_q),
		.order   (order_q),
		.u_s1    (u_s1),
		.v_s1    (v_s1),
		.cx_s1   (cx_s1),
		.cy_s1   (cy_s1),
		.ctl_s1  (ctl_s1)
	);

	bce_lerp #(.CW(CW), .F(F)) u_lerp_x (
		.clk  (clk),
		.en   (adv[2]),
		.u    (u_s1),
		.v    (v_s1),
		.a    (cx_s1[0]),
		.b    (cx_s1[1]),
		.c    (cx_s1[2]),
		.d    (cx_s1[3]),
		.l_s2 (xl_s2),
		.r_s2 (xr_s2)
	);

	bce_lerp #(.CW(CW), .F(F)) u_lerp_y (
		.clk  (clk),
		.en   (adv[2]),
		.u    (u_s1),
		.v    (v_s1),
		.a    (cy_s1[0]),
		.b    (cy_s1[1]),
		.c    (cy_s1[2]),
		.d    (cy_s1[3]),
		.l_s2 (yl_s2),
		.r_s2 (yr_s2)
	);

	// Side data: u and v for the second level, then the third-level factors.
	// The quadratic curve scales by one at the third level to share the shift.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			u_s2   <= u_s1;
			v_s2   <= v_s1;
			ctl_s2 <= ctl_s1;
		end
		if (adv[3]) begin
			u_s3   <= u_s2;
			v_s3   <= v_s2;
			ctl_s3 <= ctl_s2;
		end
		if (adv[4]) begin
			fl_s4  <= ctl_s3.cubic ? v_s3 : ONE;
			fr_s4  <= ctl_s3.cubic ? u_s3 : ONE;
			ctl_s4 <= ctl_s3;
		end
		if (adv[5]) begin
			ctl_s5 <= ctl_s4;
		end
		if (adv[6]) begin
			ctl_s6 <= ctl_s5;
		end
	end

	bce_wide_mul #(.AW(W1), .F(F)) u_mul_xl2 (
		.clk (clk), .en_a (adv[3]), .en_b (adv[4]), .a (xl_s2), .f (v_s2), .p_s2 (xl_s4)
	);
	bce_wide_mul #(.AW(W1), .F(F)) u_mul_xr2 (
		.clk (clk), .en_a (adv[3]), .en_b (adv[4]), .a (xr_s2), .f (u_s2), .p_s2 (xr_s4)
	);
	bce_wide_mul #(.AW(W1), .F(F)) u_mul_yl2 (
		.clk (clk), .en_a (adv[3]), .en_b (adv[4]), .a (yl_s2), .f (v_s2), .p_s2 (yl_s4)
	);
	bce_wide_mul #(.AW(W1), .F(F)) u_mul_yr2 (
		.clk (clk), .en_a (adv[3]), .en_b (adv[4]), .a (yr_s2), .f (u_s2), .p_s2 (yr_s4)
	);

	bce_wide_mul #(.AW(W2), .F(F)) u_mul_xl3 (
		.clk (clk), .en_a (adv[5]), .en_b (adv[6]), .a (xl_s4), .f (fl_s4), .p_s2 (xl_s6)
	);
	bce_wide_mul #(.AW(W2), .F(F)) u_mul_xr3 (
		.clk (clk), .en_a (adv[5]), .en_b (adv[6]), .a (xr_s4), .f (fr_s4), .p_s2 (xr_s6)
	);
	bce_wide_mul #(.AW(W2), .F(F)) u_mul_yl3 (
		.clk (clk), .en_a (adv[5]), .en_b (adv[6]), .a (yl_s4), .f (fl_s4), .p_s2 (yl_s6)
	);
	bce_wide_mul #(.AW(W2), .F(F)) u_mul_yr3 (
		.clk (clk), .en_a (adv[5]), .en_b (adv[6]), .a (yr_s4), .f (fr_s4), .p_s2 (yr_s6)
	);

	bce_round_sat #(.CW(CW), .F(F)) u_round_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv[7]),
		.zero     (ctl_s6.zero),
		.l3       (xl_s6),
		.r3       (xr_s6),
		.coord_s7 (x_s7)
	);

	bce_round_sat #(.CW(CW), .F(F)) u_round_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv[7]),
		.zero     (ctl_s6.zero),
		.l3       (yl_s6),
		.r3       (yr_s6),
		.coord_s7 (y_s7)
	);

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled although the output is being taken");

	a_word_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[1])
		else $error("accepted word missing from the first stage");

	a_stalled_word_kept: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[PIPE_STAGES-1] && !adv[PIPE_STAGES-1] |=> vld_q[PIPE_STAGES-1])
		else $error("stalled word dropped inside the pipeline");

endmodule

>>> rtl/bce_coef.sv
// First pipeline stage: clamps u, forms v = 1 - u and selects the blend
// coefficients of both axes for the configured curve order. Uses bce_pkg.
`timescale 1ns / 1ps

module bce_coef #(
	parameter int CW = bce_pkg::COORD_WIDTH_DEF,
	parameter int F  = bce_pkg::PARAM_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [F:0]           param_u,
	input  logic [2*CW-1:0]      points [4],
	input  logic [1:0]           order,
	output logic [F:0]           u_s1,
	output logic [F:0]           v_s1,
	output logic signed [CW+1:0] cx_s1 [4],
	output logic signed [CW+1:0] cy_s1 [4],
	output bce_pkg::ctl_t        ctl_s1
);
	import bce_pkg::*;

	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

	logic [F:0]           u_c;
	logic [F:0]           v_c;
	logic signed [CW+1:0] px [4];
	logic signed [CW+1:0] py [4];
	logic signed [CW+1:0] cx [4];
	logic signed [CW+1:0] cy [4];
	logic                 cubic;
	ctl_t                 ctl;

	always_comb begin
		u_c = (param_u > ONE) ? ONE : param_u;
		v_c = ONE - u_c;
		for (int i = 0; i < 4; i++) begin
			px[i] = (CW+2)'($signed(points[i][2*CW-1:CW]));
			py[i] = (CW+2)'($signed(points[i][CW-1:0]));
		end
		cubic = (order == ORDER_CUBIC);
		ctl.cubic = cubic;
		ctl.zero = !((order == ORDER_QUAD) || (order == ORDER_CUBIC));
		// Cubic weights are 1, 3, 3, 1; the quadratic form reuses the middle
		// point on both sides, which gives its weight of 2.
		cx[0] = px[0];
		cy[0] = py[0];
		if (cubic) begin
			cx[1] = (px[1] <<< 1) + px[1];
			cx[2] = (px[2] <<< 1) + px[2];
			cx[3] = px[3];
			cy[1] = (py[1] <<< 1) + py[1];
			cy[2] = (py[2] <<< 1) + py[2];
			cy[3] = py[3];
		end else begin
			cx[1] = px[1];
			cx[2] = px[1];
			cx[3] = px[2];
			cy[1] = py[1];
			cy[2] = py[1];
			cy[3] = py[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1   <= u_c;
			v_s1   <= v_c;
			cx_s1  <= cx;
			cy_s1  <= cy;
			ctl_s1 <= ctl;
		end
	end

	a_param_split: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (u_s1 <= ONE) && ((F+2)'(u_s1) + (F+2)'(v_s1) == (F+2)'(ONE)))
		else $error("u and v do not add up to one");

endmodule

>>> rtl/bce_lerp.sv
// Second pipeline stage for one axis: the first blend level, two weighted
// sums of coefficient pairs by v and u. Uses bce_pkg for defaults.
`timescale 1ns / 1ps

module bce_lerp #(
	parameter int CW = bce_pkg::COORD_WIDTH_DEF,
	parameter int F  = bce_pkg::PARAM_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [F:0]             u,
	input  logic [F:0]             v,
	input  logic signed [CW+1:0]   a,
	input  logic signed [CW+1:0]   b,
	input  logic signed [CW+1:0]   c,
	input  logic signed [CW+1:0]   d,
	output logic signed [CW+F+1:0] l_s2,
	output logic signed [CW+F+1:0] r_s2
);
	localparam int W1 = CW + F + 2;

	logic signed [F+1:0] us;
	logic signed [F+1:0] vs;
	logic signed [W1-1:0] l_c;
	logic signed [W1-1:0] r_c;

	always_comb begin
		us  = $signed({1'b0, u});
		vs  = $signed({1'b0, v});
		l_c = W1'(vs) * W1'(a) + W1'(us) * W1'(b);
		r_c = W1'(vs) * W1'(c) + W1'(us) * W1'(d);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s2 <= l_c;
			r_s2 <= r_c;
		end
	end

endmodule

>>> rtl/bce_wide_mul.sv
// Two-stage multiplier of a wide signed value by an unsigned Q1.F factor.
// The wide operand is cut into limbs; partial products are registered, then
// summed. Uses bce_pkg for the limb width.
`timescale 1ns / 1ps

module bce_wide_mul #(
	parameter int AW = 34,
	parameter int F  = bce_pkg::PARAM_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  en_a,
	input  logic                  en_b,
	input  logic signed [AW-1:0]  a,
	input  logic [F:0]            f,
	output logic signed [AW+F-1:0] p_s2
);
	import bce_pkg::*;

	localparam int FW  = F + 1;
	localparam int OW  = AW + F;
	localparam int NL  = (AW + LIMB_W - 1) / LIMB_W;
	localparam int EW  = NL * LIMB_W + 1;
	localparam int PPW = LIMB_W + FW + 2;
	localparam int SW  = NL * LIMB_W + FW + 2;

	logic [EW-1:0]         a_ext;
	logic signed [FW:0]    fs;
	logic signed [PPW-1:0] pp_s1 [NL];
	logic signed [SW-1:0]  acc;

	assign a_ext = {{(EW-AW){a[AW-1]}}, a};
	assign fs    = $signed({1'b0, f});

	for (genvar i = 0; i < NL; i++) begin : g_limb
		logic signed [LIMB_W:0] limb;
		if (i == NL - 1) begin : g_top
			assign limb = a_ext[i*LIMB_W +: LIMB_W+1];
		end else begin : g_low
			assign limb = {1'b0, a_ext[i*LIMB_W +: LIMB_W]};
		end
		always_ff @(posedge clk) begin
			if (en_a) begin
				pp_s1[i] <= PPW'(limb) * PPW'(fs);
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NL; i++) begin
			acc = acc + (SW'(pp_s1[i]) <<< (i * LIMB_W));
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			p_s2 <= acc[OW-1:0];
		end
	end

endmodule

>>> rtl/bce_round_sat.sv
// Last pipeline stage for one axis: adds the two blend halves, rounds to
// nearest with ties upward, and saturates to the coordinate width. Uses bce_pkg.
`timescale 1ns / 1ps

module bce_round_sat #(
	parameter int CW = bce_pkg::COORD_WIDTH_DEF,
	parameter int F  = bce_pkg::PARAM_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       zero,
	input  logic signed [CW+3*F+1:0]   l3,
	input  logic signed [CW+3*F+1:0]   r3,
	output logic signed [CW-1:0]       coord_s7
);
	localparam int W3 = CW + 3 * F + 2;
	localparam int WS = W3 + 1;
	localparam int SH = 3 * F;
	localparam logic signed [WS-1:0] HALF = WS'(1) <<< (SH - 1);
	localparam logic signed [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};

	logic signed [WS-1:0] sum;
	logic [CW+2:0]        q;
	logic                 fits;
	logic signed [CW-1:0] res;

	always_comb begin
		sum  = WS'(l3) + WS'(r3) + HALF;
		q    = sum[WS-1:SH];
		fits = (&q[CW+2:CW-1]) || !(|q[CW+2:CW-1]);
		if (zero) begin
			res = '0;
		end else if (fits) begin
			res = q[CW-1:0];
		end else begin
			res = q[CW+2] ? MIN_C : MAX_C;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coord_s7 <= res;
		end
	end

	a_zero_order: assert property (@(posedge clk) disable iff (!arst_n)
		en && zero |=> coord_s7 == '0)
		else $error("unused curve order did not give the origin");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		en && !zero && !fits |=> (coord_s7 == MAX_C) || (coord_s7 == MIN_C))
		else $error("overflowing blend not saturated");

endmodule

>>> tb/sv/tb_bezier_curve_evaluate.sv
`timescale 1ns / 1ps
// Self-checking testbench for bezier_curve_evaluate: streams parameter words through
// the evaluator and compares every returned curve point with an exact blend predictor.
// Depends on bce_pkg and the bezier_curve_evaluate RTL.

module tb_bezier_curve_evaluate;

	import bce_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int FB = PARAM_FRAC_BITS_DEF;
	localparam int S_W = ((FB + 8) / 8) * 8;
	localparam int M_W = ((2 * CW + 7) / 8) * 8;
	localparam int U_ONE = 1 << FB;
	localparam int U_MAX = (1 << (FB + 1)) - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_WORDS = 110;

	typedef enum int {
		RX_ALWAYS = 0,
		RX_CHOPPY = 1,
		RX_BURSTY = 2
	} rx_mode_t;

	typedef struct packed {
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] x;
	} point_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;
	logic cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [2*CW-1:0] cfg_data = '0;

	logic [2*CW-1:0] ctrl_pts [4];
	logic [1:0] curve_deg;

	logic [FB:0] pending_params [$];
	point_t expected_points [$];

	int mismatches = 0;
	int cycles = 0;
	bit word_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	bit sender_steady = 1'b0;
	rx_mode_t rx_mode = RX_CHOPPY;
	int rx_stall_left = 0;
	bit long_hold_arm = 1'b0;
	bit long_hold_done = 1'b0;
	int long_hold_left = 0;

	bezier_curve_evaluate dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [CW-1:0] blend_axis(input logic signed [CW-1:0] c0,
			input logic signed [CW-1:0] c1, input logic signed [CW-1:0] c2,
			input logic signed [CW-1:0] c3, input logic [1:0] deg, input logic [FB:0] u_raw);
		logic signed [127:0] k0, k1, k2, k3, uu, vv, acc;
		int sh;
		k0 = 128'(c0);
		k1 = 128'(c1);
		k2 = 128'(c2);
		k3 = 128'(c3);
		uu = (32'(u_raw) > U_ONE) ? 128'sd1 <<< FB : $signed({{(127 - FB){1'b0}}, u_raw});
		vv = (128'sd1 <<< FB) - uu;
		if (deg == ORDER_CUBIC) begin
			acc = k0 * vv * vv * vv + 3 * k1 * uu * vv * vv + 3 * k2 * uu * uu * vv
				+ k3 * uu * uu * uu;
			sh = 3 * FB;
		end else begin
			acc = k0 * vv * vv + 2 * k1 * uu * vv + k2 * uu * uu;
			sh = 2 * FB;
		end
		acc = (acc + (128'sd1 <<< (sh - 1))) >>> sh;
		if (acc > (128'sd1 <<< (CW - 1)) - 1)
			return {1'b0, {(CW - 1){1'b1}}};
		if (acc < -(128'sd1 <<< (CW - 1)))
			return {1'b1, {(CW - 1){1'b0}}};
		return acc[CW-1:0];
	endfunction

	function automatic point_t bezier_point(input logic [FB:0] u_raw);
		point_t p;
		p = '0;
		if (curve_deg == ORDER_QUAD || curve_deg == ORDER_CUBIC) begin
			p.x = blend_axis(ctrl_pts[0][2*CW-1:CW], ctrl_pts[1][2*CW-1:CW],
				ctrl_pts[2][2*CW-1:CW], ctrl_pts[3][2*CW-1:CW], curve_deg, u_raw);
			p.y = blend_axis(ctrl_pts[0][CW-1:0], ctrl_pts[1][CW-1:0],
				ctrl_pts[2][CW-1:0], ctrl_pts[3][CW-1:0], curve_deg, u_raw);
		end
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [2*CW-1:0] value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_POINT_ZERO: ctrl_pts[0] = value;
			REG_POINT_ONE: ctrl_pts[1] = value;
			REG_POINT_TWO: ctrl_pts[2] = value;
			REG_POINT_THREE: ctrl_pts[3] = value;
			REG_CURVE_ORDER: curve_deg = value[1:0];
			default: ;
		endcase
	endtask

	task automatic set_curve(input logic [2*CW-1:0] p0, input logic [2*CW-1:0] p1,
			input logic [2*CW-1:0] p2, input logic [2*CW-1:0] p3,
			input logic [2*CW-1:0] order_word);
		write_reg(REG_POINT_ZERO, p0);
		write_reg(REG_POINT_ONE, p1);
		write_reg(REG_POINT_TWO, p2);
		write_reg(REG_POINT_THREE, p3);
		write_reg(REG_CURVE_ORDER, order_word);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_params.size() != 0 || expected_points.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [CW-1:0] pick_coord(input bit extreme);
		if (!extreme)
			return CW'($urandom);
		case ($urandom_range(0, 3))
			0: return {1'b1, {(CW - 1){1'b0}}};
			1: return {1'b0, {(CW - 1){1'b1}}};
			2: return '0;
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic logic [FB:0] pick_param();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: return '0;
					1: return (FB + 1)'(1);
					2: return (FB + 1)'(U_ONE - 1);
					3: return (FB + 1)'(U_ONE);
					4: return (FB + 1)'(U_ONE + 1);
					default: return (FB + 1)'(U_MAX);
				endcase
			end
			1: return (FB + 1)'($urandom_range(0, U_MAX));
			default: return (FB + 1)'($urandom_range(0, U_ONE));
		endcase
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		word_taken = s_tvalid && s_tready;
		if (word_taken) begin
			expected_points.push_back(bezier_point(pending_params[0]));
			pending_params.pop_front();
		end
	end

	always @(negedge clk) begin
		if (!(s_tvalid && !word_taken)) begin
			if (!sender_steady && gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_params.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= S_W'(pending_params[0]);
				if (!sender_steady) begin
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (long_hold_left > 0) begin
			long_hold_left--;
			m_tready <= 1'b0;
		end else if (long_hold_arm && !long_hold_done && pending_params.size() > 0) begin
			long_hold_done = 1'b1;
			long_hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_CHOPPY: begin
					if ($urandom_range(0, 1) == 0) begin
						m_tready <= 1'b0;
						rx_stall_left = $urandom_range(0, 2);
					end else begin
						m_tready <= 1'b1;
					end
				end
				default: begin
					if ($urandom_range(0, 15) == 0) begin
						m_tready <= 1'b0;
						rx_stall_left = $urandom_range(3, 20);
					end else begin
						m_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	always @(posedge clk) begin
		point_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[2*CW-1:0];
			if (expected_points.size() == 0) begin
				report_mismatch($sformatf("unexpected point x=%0d y=%0d", got.x, got.y));
			end else begin
				want = expected_points.pop_front();
				if (got.x !== want.x)
					report_mismatch($sformatf("point_x got %0d want %0d", got.x, want.x));
				if (got.y !== want.y)
					report_mismatch($sformatf("point_y got %0d want %0d", got.y, want.y));
			end
		end
	end

	initial begin
		int ph, n;
		bit extreme;
		logic [1:0] deg;
		logic [2*CW-1:0] pts [4];
		ctrl_pts[0] = '0;
		ctrl_pts[1] = '0;
		ctrl_pts[2] = '0;
		ctrl_pts[3] = '0;
		curve_deg = ORDER_RESET;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		pending_params.push_back('0);
		pending_params.push_back((FB + 1)'(U_ONE / 3));
		wait_drained();

		set_curve(32'h8000_7FFF, 32'h7FFF_8000, 32'h8000_8000, 32'h7FFF_7FFF,
			{30'd0, ORDER_CUBIC});
		pending_params.push_back('0);
		pending_params.push_back((FB + 1)'(1));
		pending_params.push_back((FB + 1)'(U_ONE / 2));
		pending_params.push_back((FB + 1)'(U_ONE - 1));
		pending_params.push_back((FB + 1)'(U_ONE));
		pending_params.push_back((FB + 1)'(U_ONE + 1));
		pending_params.push_back((FB + 1)'(U_MAX));
		pending_params.push_back((FB + 1)'(U_ONE + U_ONE / 2));
		wait_drained();

		// Symmetric quadratic with a half-way point landing exactly on a rounding tie.
		set_curve(32'h0001_FFFF, 32'h0000_0000, 32'h0001_FFFF, 32'h7FFF_8000,
			{30'd0, ORDER_QUAD});
		pending_params.push_back((FB + 1)'(U_ONE / 2));
		pending_params.push_back('0);
		pending_params.push_back((FB + 1)'(U_ONE));
		pending_params.push_back((FB + 1)'(U_ONE / 4));
		pending_params.push_back((FB + 1)'(U_MAX));
		wait_drained();

		set_curve(32'h7FFF_7FFF, 32'h1234_5678, 32'h8000_8000, 32'hFFFF_0001, 32'd0);
		pending_params.push_back((FB + 1)'(12345));
		pending_params.push_back((FB + 1)'(U_ONE));
		wait_drained();
		write_reg(REG_CURVE_ORDER, 32'hFFFF_FFFD);
		@(posedge clk);
		pending_params.push_back('0);
		pending_params.push_back((FB + 1)'(U_ONE + 34463));
		wait_drained();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			extreme = (ph % 4 == 2);
			for (n = 0; n < 4; n++)
				pts[n] = {pick_coord(extreme), pick_coord(extreme)};
			case (ph % 6)
				0, 3: deg = ORDER_CUBIC;
				1, 4: deg = ORDER_QUAD;
				2: deg = 2'd0;
				default: deg = 2'($urandom_range(0, 3));
			endcase
			if (ph == 7)
				deg = 2'd1;
			set_curve(pts[0], pts[1], pts[2], pts[3], ($urandom & ~32'h3) | 32'(deg));
			sender_steady = (ph == 1 || ph == 8);
			rx_mode = rx_mode_t'(ph % 3);
			long_hold_arm = (ph == 4 || ph == 10);
			long_hold_done = 1'b0;
			for (n = 0; n < PHASE_WORDS; n++)
				pending_params.push_back(pick_param());
			wait_drained();
			long_hold_arm = 1'b0;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/bce_pkg.sv
rtl/bce_coef.sv
rtl/bce_lerp.sv
rtl/bce_wide_mul.sv
rtl/bce_round_sat.sv
rtl/bezier_curve_evaluate.sv
tb/sv/tb_bezier_curve_evaluate.sv
